### hw/rtl/refcounted_block_allocator_macros.svh
// Assertion macros used by the allocator checker.
`ifndef REFCOUNTED_BLOCK_ALLOCATOR_MACROS_SVH
`define REFCOUNTED_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define RCBA_ASSERT_IMM(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RCBA_ASSERT_NXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rcba_pkg.sv
// Types, codes and sizes shared by the reference-counted block allocator.
`timescale 1ns / 1ps

package rcba_pkg;

    localparam int NUM_BLOCKS  = 256;
    localparam int COUNT_BITS  = 16;
    localparam int GEN_BITS    = 32;
    localparam int ID_BITS     = 8;
    localparam int POS_BITS    = $clog2(NUM_BLOCKS);
    localparam int TOTAL_BITS  = 9;
    localparam int STRIDE_BITS = 32;
    localparam int BASE_BITS   = 48;
    localparam int ADDR_BITS   = 49;
    localparam int PROD_BITS   = ID_BITS + STRIDE_BITS;
    localparam int APB_DW      = 64;
    localparam int APB_AW      = 4;

    localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = STRIDE_BITS'(64);

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_RETAIN  = 2'd2;
    localparam logic [1:0] OP_QUERY   = 2'd3;

    localparam logic [1:0] ST_FREE   = 2'd0;
    localparam logic [1:0] ST_ACTIVE = 2'd1;
    localparam logic [1:0] ST_SHARED = 2'd2;

    localparam logic [2:0] STS_OK         = 3'd0;
    localparam logic [2:0] STS_NO_FREE    = 3'd1;
    localparam logic [2:0] STS_RANGE      = 3'd2;
    localparam logic [2:0] STS_NOT_IN_USE = 3'd3;
    localparam logic [2:0] STS_SATURATED  = 3'd4;

    localparam logic REG_STRIDE = 1'b0;
    localparam logic REG_BASE   = 1'b1;

    typedef logic [ID_BITS-1:0]    id_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [GEN_BITS-1:0]   gen_t;
    typedef logic [1:0]            bstate_t;
    typedef logic [TOTAL_BITS-1:0] total_t;

    localparam count_t COUNT_MAX = '1;

    typedef struct packed {
        count_t  refs;
        bstate_t state;
        gen_t    gen;
    } tbl_entry_t;

    typedef struct packed {
        logic       en;
        id_t        addr;
        tbl_entry_t data;
    } tbl_wr_t;

    typedef struct packed {
        gen_t gen;
        id_t  id;
    } stk_entry_t;

    typedef struct packed {
        logic       pop;
        logic       push;
        stk_entry_t data;
    } stk_cmd_t;

    typedef struct packed {
        logic [1:0]           pad;
        total_t               shared_count;
        total_t               active_count;
        total_t               free_count;
        logic [ADDR_BITS-1:0] frame_address;
        gen_t                 generation;
        bstate_t              block_state;
        count_t               reference_count;
        id_t                  result_block;
    } out_beat_t;

endpackage

### hw/rtl/refcounted_block_allocator.sv
// Top level of the reference-counted block allocator.
//
//  port group | role            | beat contents
//  s_         | operation in    | tuser: operation; tdata: block_id
//  m_         | result out      | tuser: status; tdata: block fields and pool totals
//  apb        | register access | block_stride at 0x0, frame base address at 0x8
//
// One beat is taken per cycle while s_tready is high; after its beat is accepted, each result
// passes table and stack read, execute with read-modify-write forwarding, and address add.
// Reset is synchronous; tables and stack read as their reset contents through
// per-entry valid bits, so the block accepts beats as soon as reset is released.
// A stall on m_ holds the pipeline registers; s_tready falls once all three stages
// hold a beat.
`timescale 1ns / 1ps

module refcounted_block_allocator import rcba_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] block_id
    input  logic [1:0]         s_tuser,   // [1:0] operation
    output logic               m_tvalid,
    input  logic               m_tready,
    // [7:0] result_block, [23:8] reference_count, [25:24] block_state,
    // [57:26] generation, [106:58] frame_address, [115:107] free_count,
    // [124:116] active_count, [133:125] shared_count, [135:134] zero
    output logic [135:0]       m_tdata,
    output logic [2:0]         m_tuser,   // [2:0] status
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    logic [STRIDE_BITS-1:0] stride_reg;
    logic [BASE_BITS-1:0]   base_reg;

    logic        s1_valid_reg;
    logic [1:0]  s1_op_reg;
    id_t         s1_id_reg;

    logic                   s2_valid_reg;
    logic [2:0]             s2_status_reg;
    id_t                    s2_block_reg;
    tbl_entry_t             s2_entry_reg;
    logic [PROD_BITS-1:0]   s2_prod_reg;
    logic                   s2_addr_en_reg;
    total_t                 s2_free_reg;
    total_t                 s2_active_reg;
    total_t                 s2_shared_reg;

    logic        m_valid_reg;
    out_beat_t   m_data_reg;
    logic [2:0]  m_user_reg;

    total_t      active_reg;
    total_t      shared_reg;

    logic        out_free;
    logic        s2_adv;
    logic        s2_free;
    logic        s1_fire;
    logic        accept;

    tbl_entry_t  tbl_rd;
    tbl_wr_t     tbl_wr;
    stk_entry_t  stk_top;
    stk_cmd_t    stk_cmd;
    total_t      depth;

    logic [2:0]  status_next;
    id_t         block_next;
    tbl_entry_t  entry_next;
    logic        addr_en_next;
    logic        chg;
    bstate_t     prev_state;
    count_t      refs_dec;
    total_t      depth_next;
    total_t      active_next;
    total_t      shared_next;
    logic        out_of_range;
    logic [ADDR_BITS-1:0] frame_next;

    // handshake chain
    assign out_free = !m_valid_reg || m_tready;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_fire  = s1_valid_reg && s2_free;
    assign s_tready = !s1_valid_reg || s2_free;
    assign accept   = s_tvalid && s_tready;

    // register port
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stride_reg <= STRIDE_RESET;
            base_reg   <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3])
                REG_STRIDE: stride_reg <= pwdata[STRIDE_BITS-1:0];
                REG_BASE:   base_reg   <= pwdata[BASE_BITS-1:0];
                default:    stride_reg <= stride_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3])
            REG_STRIDE: prdata = APB_DW'(stride_reg);
            REG_BASE:   prdata = APB_DW'(base_reg);
            default:    prdata = '0;
        endcase
    end

    rcba_block_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (s_tdata[ID_BITS-1:0]),
        .wr      (tbl_wr),
        .rd_data (tbl_rd)
    );

    rcba_free_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .cmd     (stk_cmd),
        .top     (stk_top),
        .depth   (depth)
    );

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg <= s_tuser;
            s1_id_reg <= s_tdata[ID_BITS-1:0];
        end
    end

    // execute
    assign out_of_range = TOTAL_BITS'(s1_id_reg) >= TOTAL_BITS'(NUM_BLOCKS);
    assign refs_dec     = tbl_rd.refs - COUNT_BITS'(1);

    always_comb begin
        status_next  = STS_OK;
        block_next   = s1_id_reg;
        entry_next   = tbl_rd;
        addr_en_next = 1'b1;
        chg          = 1'b0;
        prev_state   = tbl_rd.state;
        depth_next   = depth;
        active_next  = active_reg;
        shared_next  = shared_reg;
        stk_cmd      = '0;

        if (s1_op_reg == OP_ALLOC) begin
            if (depth == '0) begin
                status_next  = STS_NO_FREE;
                block_next   = '0;
                entry_next   = '0;
                addr_en_next = 1'b0;
            end else begin
                block_next   = stk_top.id;
                entry_next   = '{refs: COUNT_BITS'(1), state: ST_ACTIVE, gen: stk_top.gen};
                prev_state   = ST_FREE;
                chg          = 1'b1;
                stk_cmd.pop  = 1'b1;
                depth_next   = depth - TOTAL_BITS'(1);
            end
        end else if (out_of_range) begin
            status_next  = STS_RANGE;
            entry_next   = '0;
            addr_en_next = 1'b0;
        end else if (s1_op_reg == OP_QUERY) begin
            status_next = STS_OK;
        end else if (tbl_rd.refs == '0) begin
            status_next = STS_NOT_IN_USE;
        end else if (s1_op_reg == OP_RETAIN) begin
            if (tbl_rd.refs == COUNT_MAX) begin
                status_next = STS_SATURATED;
            end else begin
                entry_next.refs  = tbl_rd.refs + COUNT_BITS'(1);
                entry_next.state = ST_SHARED;
                chg              = 1'b1;
            end
        end else begin
            entry_next.refs = refs_dec;
            chg             = 1'b1;
            if (refs_dec == '0) begin
                entry_next.state = ST_FREE;
                entry_next.gen   = tbl_rd.gen + GEN_BITS'(1);
                if (depth < TOTAL_BITS'(NUM_BLOCKS)) begin
                    stk_cmd.push = 1'b1;
                    depth_next   = depth + TOTAL_BITS'(1);
                end
            end else if (refs_dec == COUNT_BITS'(1)) begin
                entry_next.state = ST_ACTIVE;
            end
        end

        stk_cmd.data = '{gen: entry_next.gen, id: block_next};

        if (chg && (prev_state != entry_next.state)) begin
            if (prev_state == ST_ACTIVE) begin
                active_next = active_next - TOTAL_BITS'(1);
            end else if (prev_state == ST_SHARED) begin
                shared_next = shared_next - TOTAL_BITS'(1);
            end
            if (entry_next.state == ST_ACTIVE) begin
                active_next = active_next + TOTAL_BITS'(1);
            end else if (entry_next.state == ST_SHARED) begin
                shared_next = shared_next + TOTAL_BITS'(1);
            end
        end

        if (!s1_fire) begin
            stk_cmd.pop  = 1'b0;
            stk_cmd.push = 1'b0;
        end
    end

    assign tbl_wr = '{en: s1_fire && chg, addr: block_next, data: entry_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            shared_reg <= '0;
        end else if (s1_fire) begin
            active_reg <= active_next;
            shared_reg <= shared_next;
        end
    end

    // execute result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            s2_valid_reg <= 1'b1;
        end else if (s2_adv) begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            s2_status_reg  <= status_next;
            s2_block_reg   <= block_next;
            s2_entry_reg   <= entry_next;
            s2_prod_reg    <= PROD_BITS'(block_next) * PROD_BITS'(stride_reg);
            s2_addr_en_reg <= addr_en_next;
            s2_free_reg    <= depth_next;
            s2_active_reg  <= active_next;
            s2_shared_reg  <= shared_next;
        end
    end

    // output stage
    assign frame_next = s2_addr_en_reg ?
        ADDR_BITS'(base_reg) + ADDR_BITS'(s2_prod_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s2_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            m_user_reg <= s2_status_reg;
            m_data_reg <= '{
                pad:             '0,
                shared_count:    s2_shared_reg,
                active_count:    s2_active_reg,
                free_count:      s2_free_reg,
                frame_address:   frame_next,
                generation:      s2_entry_reg.gen,
                block_state:     s2_entry_reg.state,
                reference_count: s2_entry_reg.refs,
                result_block:    s2_block_reg
            };
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

### hw/rtl/rcba_block_table.sv
// Per-block table of reference count, state and generation, with write forwarding.
`timescale 1ns / 1ps

module rcba_block_table import rcba_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       rd_en,
    input  id_t        rd_addr,
    input  tbl_wr_t    wr,
    output tbl_entry_t rd_data
);

    tbl_entry_t              entry_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0]   valid_reg;
    tbl_entry_t              mem_q_reg;
    tbl_entry_t              fwd_reg;
    logic                    valid_q_reg;
    logic                    hit_q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            entry_mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mem_q_reg   <= entry_mem[rd_addr];
            valid_q_reg <= valid_reg[rd_addr];
            hit_q_reg   <= wr.en && (wr.addr == rd_addr);
            fwd_reg     <= wr.data;
        end
    end

    always_comb begin
        if (hit_q_reg) begin
            rd_data = fwd_reg;
        end else if (valid_q_reg) begin
            rd_data = mem_q_reg;
        end else begin
            rd_data = '0;
        end
    end

endmodule

### hw/rtl/rcba_free_stack.sv
// LIFO free stack of block ids with their generations, top entry forwarded.
`timescale 1ns / 1ps

module rcba_free_stack import rcba_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       rd_en,
    input  stk_cmd_t   cmd,
    output stk_entry_t top,
    output total_t     depth
);

    stk_entry_t              stack_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0]   valid_reg;
    total_t                  depth_reg;
    total_t                  depth_next;
    logic [POS_BITS-1:0]     pos1;
    logic [POS_BITS-1:0]     pos2;
    logic [POS_BITS-1:0]     wpos;
    stk_entry_t              e1_reg;
    stk_entry_t              e2_reg;
    logic                    v1_reg;
    logic                    v2_reg;
    logic [POS_BITS-1:0]     p1_reg;
    logic [POS_BITS-1:0]     p2_reg;
    logic                    pop_q_reg;
    logic                    push_q_reg;
    stk_entry_t              fwd_reg;

    assign pos1  = POS_BITS'(depth_reg - TOTAL_BITS'(1));
    assign pos2  = POS_BITS'(depth_reg - TOTAL_BITS'(2));
    assign wpos  = POS_BITS'(depth_reg);
    assign depth = depth_reg;

    always_comb begin
        depth_next = depth_reg;
        if (cmd.pop) begin
            depth_next = depth_reg - TOTAL_BITS'(1);
        end else if (cmd.push) begin
            depth_next = depth_reg + TOTAL_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= TOTAL_BITS'(NUM_BLOCKS);
            valid_reg <= '0;
        end else begin
            depth_reg <= depth_next;
            if (cmd.push) begin
                valid_reg[wpos] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            stack_mem[wpos] <= cmd.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            e1_reg     <= stack_mem[pos1];
            e2_reg     <= stack_mem[pos2];
            v1_reg     <= valid_reg[pos1];
            v2_reg     <= valid_reg[pos2];
            p1_reg     <= pos1;
            p2_reg     <= pos2;
            pop_q_reg  <= cmd.pop;
            push_q_reg <= cmd.push;
            fwd_reg    <= cmd.data;
        end
    end

    always_comb begin
        if (push_q_reg) begin
            top = fwd_reg;
        end else if (pop_q_reg) begin
            top = v2_reg ? e2_reg : stk_entry_t'{gen: '0, id: ID_BITS'(p2_reg)};
        end else begin
            top = v1_reg ? e1_reg : stk_entry_t'{gen: '0, id: ID_BITS'(p1_reg)};
        end
    end

endmodule

### hw/rtl/rcba_checker.sv
// Port-level checks on the allocator, bound to the top level.
`timescale 1ns / 1ps
`include "refcounted_block_allocator_macros.svh"

module rcba_checker import rcba_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [135:0]       m_tdata,
    input logic [2:0]         m_tuser
);

    out_beat_t                beat;
    logic [TOTAL_BITS+1:0]    pool_sum;

    assign beat     = m_tdata;
    assign pool_sum = (TOTAL_BITS+2)'(beat.free_count) + (TOTAL_BITS+2)'(beat.active_count)
                    + (TOTAL_BITS+2)'(beat.shared_count);

    `RCBA_ASSERT_NXT(a_out_hold, aclk, !aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")
    `RCBA_ASSERT_IMM(a_pool_sum, aclk, !aresetn, m_tvalid, pool_sum == (TOTAL_BITS+2)'(NUM_BLOCKS), "free, active and shared totals do not cover the pool")
    `RCBA_ASSERT_IMM(a_empty_alloc, aclk, !aresetn, m_tvalid && (m_tuser == STS_NO_FREE), (beat.free_count == '0) && (beat.frame_address == '0), "failed allocate with free blocks left")
    `RCBA_ASSERT_NXT(a_reset_idle, aclk, 1'b0, !aresetn, !m_tvalid, "result beat presented straight after reset")

endmodule

bind refcounted_block_allocator rcba_checker u_rcba_checker (.*);

### sim/refcounted_block_allocator_tb.sv
// Self-checking testbench for the reference-counted block allocator: random and directed beats.
`timescale 1ns / 1ps

module refcounted_block_allocator_tb;
    import rcba_pkg::*;

    typedef struct {
        logic [2:0] status;
        out_beat_t  beat;
    } due_t;

    class allocator_tracker;
        id_t                    free_ids[NUM_BLOCKS];
        int                     depth;
        count_t                 refs[NUM_BLOCKS];
        gen_t                   gens[NUM_BLOCKS];
        bstate_t                states[NUM_BLOCKS];
        int                     n_active;
        int                     n_shared;
        logic [STRIDE_BITS-1:0] stride;
        logic [BASE_BITS-1:0]   base;
        due_t                   due[$];
        int                     errors;

        function new();
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                free_ids[i] = id_t'(i);
                refs[i]     = '0;
                gens[i]     = '0;
                states[i]   = ST_FREE;
            end
            depth    = NUM_BLOCKS;
            n_active = 0;
            n_shared = 0;
            stride   = STRIDE_RESET;
            base     = '0;
            errors   = 0;
        endfunction

        function void move_state(id_t b, bstate_t next);
            if (states[b] == next)
                return;
            if (states[b] == ST_ACTIVE)
                n_active--;
            else if (states[b] == ST_SHARED)
                n_shared--;
            if (next == ST_ACTIVE)
                n_active++;
            else if (next == ST_SHARED)
                n_shared++;
            states[b] = next;
        endfunction

        function out_beat_t block_view(id_t b);
            out_beat_t v;
            v                 = '0;
            v.result_block    = b;
            v.reference_count = refs[b];
            v.block_state     = states[b];
            v.generation      = gens[b];
            v.frame_address   = ADDR_BITS'(base) + ADDR_BITS'(b) * ADDR_BITS'(stride);
            return v;
        endfunction

        function void note_op(logic [1:0] op, id_t id);
            due_t d;
            id_t  tgt;
            d.status = STS_OK;
            d.beat   = '0;
            tgt      = id;
            if (op == OP_ALLOC) begin
                if (depth == 0) begin
                    d.status = STS_NO_FREE;
                end else begin
                    depth--;
                    tgt       = free_ids[depth];
                    refs[tgt] = count_t'(1);
                    move_state(tgt, ST_ACTIVE);
                    d.beat = block_view(tgt);
                end
            end else if (op == OP_QUERY) begin
                d.beat = block_view(tgt);
            end else if (refs[tgt] == '0) begin
                d.status = STS_NOT_IN_USE;
                d.beat   = block_view(tgt);
            end else if (op == OP_RETAIN) begin
                if (refs[tgt] == COUNT_MAX) begin
                    d.status = STS_SATURATED;
                end else begin
                    refs[tgt]++;
                    move_state(tgt, ST_SHARED);
                end
                d.beat = block_view(tgt);
            end else begin
                refs[tgt]--;
                if (refs[tgt] == '0) begin
                    move_state(tgt, ST_FREE);
                    gens[tgt]++;
                    if (depth < NUM_BLOCKS) begin
                        free_ids[depth] = tgt;
                        depth++;
                    end
                end else if (refs[tgt] == count_t'(1)) begin
                    move_state(tgt, ST_ACTIVE);
                end
                d.beat = block_view(tgt);
            end
            d.beat.free_count   = total_t'(depth);
            d.beat.active_count = total_t'(n_active);
            d.beat.shared_count = total_t'(n_shared);
            due = {due, d};
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] seen);
            if (want !== seen) begin
                errors++;
                $display("%0t: %s expected 0x%0h got 0x%0h", $time, field, want, seen);
            end
        endfunction

        function void check_result(logic [2:0] sts, logic [135:0] data);
            out_beat_t got;
            due_t      d;
            got = data;
            if (due.size() == 0) begin
                errors++;
                $display("%0t: result expected none got status %0d block 0x%0h",
                         $time, sts, got.result_block);
                return;
            end
            d = due.pop_front();
            compare("status", 64'(d.status), 64'(sts));
            compare("result_block", 64'(d.beat.result_block), 64'(got.result_block));
            compare("reference_count", 64'(d.beat.reference_count),
                    64'(got.reference_count));
            compare("block_state", 64'(d.beat.block_state), 64'(got.block_state));
            compare("generation", 64'(d.beat.generation), 64'(got.generation));
            compare("frame_address", 64'(d.beat.frame_address), 64'(got.frame_address));
            compare("free_count", 64'(d.beat.free_count), 64'(got.free_count));
            compare("active_count", 64'(d.beat.active_count), 64'(got.active_count));
            compare("shared_count", 64'(d.beat.shared_count), 64'(got.shared_count));
        endfunction

        function id_t pick_live();
            int start;
            start = $urandom_range(0, NUM_BLOCKS - 1);
            for (int k = 0; k < NUM_BLOCKS; k++) begin
                if (refs[(start + k) % NUM_BLOCKS] != '0)
                    return id_t'((start + k) % NUM_BLOCKS);
            end
            return id_t'(start);
        endfunction
    endclass

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    wire               s_tready;
    logic [7:0]        s_tdata  = '0;
    logic [1:0]        s_tuser  = '0;
    wire               m_tvalid;
    logic              m_tready = 1'b0;
    wire  [135:0]      m_tdata;
    wire  [2:0]        m_tuser;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    wire  [APB_DW-1:0] prdata;
    wire               pready;

    bit quiet       = 1'b0;
    bit hold_armed  = 1'b0;

    allocator_tracker tracker = new();

    refcounted_block_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 aclk = ~aclk;

    function automatic int idle_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    task automatic send_op(logic [1:0] op, id_t id);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= id;
        do @(posedge aclk); while (!s_tready);
        tracker.note_op(op, id);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat (idle_gap()) @(posedge aclk);
        end
    endtask

    task automatic write_reg(logic reg_idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(reg_idx) << 3;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_STRIDE)
            tracker.stride = value[STRIDE_BITS-1:0];
        else
            tracker.base = value[BASE_BITS-1:0];
        @(posedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.due.size() > 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic run_mix(int n_items, int w_alloc, int w_release, int w_retain);
        int         roll;
        logic [1:0] op;
        id_t        id;
        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(0, 99);
            op   = (roll < w_alloc) ? OP_ALLOC :
                   (roll < w_alloc + w_release) ? OP_RELEASE :
                   (roll < w_alloc + w_release + w_retain) ? OP_RETAIN : OP_QUERY;
            id   = id_t'($urandom_range(0, NUM_BLOCKS - 1));
            if ((op == OP_RELEASE || op == OP_RETAIN) && $urandom_range(0, 9) != 0)
                id = tracker.pick_live();
            send_op(op, id);
        end
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_armed) begin
                hold_armed = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat (idle_gap()) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_result(m_tuser, m_tdata);
    end

    initial begin
        #10ms;
        $display("FAIL");
        $finish;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_op(OP_QUERY, 8'd0);
        send_op(OP_QUERY, 8'd255);
        send_op(OP_RELEASE, 8'd5);
        send_op(OP_RETAIN, 8'd5);
        send_op(OP_ALLOC, 8'hFF);
        send_op(OP_ALLOC, 8'd0);
        send_op(OP_RETAIN, 8'd255);
        send_op(OP_RETAIN, 8'd255);
        send_op(OP_RELEASE, 8'd255);
        send_op(OP_RELEASE, 8'd255);
        send_op(OP_RELEASE, 8'd255);
        send_op(OP_RELEASE, 8'd255);
        send_op(OP_ALLOC, 8'd17);
        send_op(OP_QUERY, 8'd255);
        send_op(OP_RELEASE, 8'd254);
        send_op(OP_QUERY, 8'd254);
        send_op(OP_RETAIN, 8'd254);
        send_op(OP_RETAIN, 8'd255);
        send_op(OP_RELEASE, 8'd255);

        hold_armed = 1'b1;
        run_mix(120, 35, 30, 20);
        settle();

        write_reg(REG_STRIDE, 64'd1);
        write_reg(REG_BASE, 64'h0000_FFFF_FFFF_FFFF);
        run_mix(100, 80, 5, 10);
        while (tracker.depth > 0)
            send_op(OP_ALLOC, id_t'($urandom_range(0, NUM_BLOCKS - 1)));
        repeat (3) send_op(OP_ALLOC, id_t'($urandom_range(0, NUM_BLOCKS - 1)));
        settle();

        write_reg(REG_STRIDE, 64'd0);
        write_reg(REG_BASE, {$urandom, $urandom});
        run_mix(100, 10, 60, 15);
        settle();

        write_reg(REG_STRIDE, 64'hFFFF_FFFF);
        write_reg(REG_BASE, {$urandom, $urandom});
        run_mix(50, 35, 30, 20);
        settle();

        quiet = 1'b1;
        write_reg(REG_STRIDE, {$urandom, $urandom});
        write_reg(REG_BASE, {$urandom, $urandom});
        run_mix(40, 35, 30, 20);
        quiet = 1'b0;
        settle();

        repeat (10) @(posedge aclk);
        if (tracker.errors == 0 && tracker.due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
